// File: rtl/mhnt_pkg.sv
// shared types and constants for the held-note tracker
package mhnt_pkg;

    localparam int NOTE_COUNT_DEF = 128;
    localparam int NOTE_W         = 7;
    localparam int PEDAL_W        = 7;
    localparam int TIME_W         = 32;
    localparam int HALF_W         = 64;
    localparam int SET_W          = 2 * HALF_W;
    localparam int PEDAL_DOWN_MIN = 64;

    typedef enum logic [2:0] {
        REQ_NOTE_ON   = 3'd0,
        REQ_NOTE_OFF  = 3'd1,
        REQ_PEDAL     = 3'd2,
        REQ_ALL_OFF   = 3'd3,
        REQ_END_BLOCK = 3'd4
    } req_type_t;

    typedef struct packed {
        req_type_t            kind;
        logic [NOTE_W-1:0]    note;
        logic [PEDAL_W-1:0]   pedal;
    } req_t;

    typedef struct packed {
        logic             emit;
        logic [SET_W-1:0] held;
    } core_status_t;

endpackage

// File: rtl/mhnt_core.sv
// note state registers and per-event update logic
module mhnt_core #(
    parameter int NOTE_COUNT = mhnt_pkg::NOTE_COUNT_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sustain_enable,
    input  logic                 step,
    input  mhnt_pkg::req_t       req,
    output mhnt_pkg::core_status_t status
);

    logic [NOTE_COUNT-1:0] held_reg;
    logic [NOTE_COUNT-1:0] held_next;
    logic [NOTE_COUNT-1:0] deferred_reg;
    logic [NOTE_COUNT-1:0] deferred_next;
    logic                  pedal_reg;
    logic                  pedal_next;
    logic                  changed_reg;
    logic                  changed_next;
    logic                  in_range;
    logic [NOTE_COUNT-1:0] mask;
    logic                  hit;
    logic                  now_down;
    logic                  emit;

    assign in_range = {1'b0, req.note} < (mhnt_pkg::NOTE_W + 1)'(NOTE_COUNT);
    assign mask     = in_range ? (NOTE_COUNT'(1) << req.note) : '0;
    assign hit      = |(held_reg & mask);
    assign now_down = req.pedal >= mhnt_pkg::PEDAL_W'(mhnt_pkg::PEDAL_DOWN_MIN);
    assign emit     = (req.kind == mhnt_pkg::REQ_END_BLOCK) && changed_reg;

    always_comb
    begin
        held_next     = held_reg;
        deferred_next = deferred_reg;
        pedal_next    = pedal_reg;
        changed_next  = changed_reg;
        case (req.kind)
            mhnt_pkg::REQ_NOTE_ON:
            begin
                deferred_next = deferred_reg & ~mask;
                held_next     = held_reg | mask;
                if (!hit && in_range)
                begin
                    changed_next = 1'b1;
                end
            end
            mhnt_pkg::REQ_NOTE_OFF:
            begin
                if (sustain_enable && pedal_reg)
                begin
                    deferred_next = deferred_reg | mask;
                end
                else
                begin
                    held_next = held_reg & ~mask;
                    if (hit)
                    begin
                        changed_next = 1'b1;
                    end
                end
            end
            mhnt_pkg::REQ_PEDAL:
            begin
                pedal_next = now_down;
                if (pedal_reg && !now_down)
                begin
                    held_next     = held_reg & ~deferred_reg;
                    deferred_next = '0;
                    if (|(held_reg & deferred_reg))
                    begin
                        changed_next = 1'b1;
                    end
                end
            end
            mhnt_pkg::REQ_ALL_OFF:
            begin
                held_next     = '0;
                deferred_next = '0;
                if (|held_reg)
                begin
                    changed_next = 1'b1;
                end
            end
            mhnt_pkg::REQ_END_BLOCK:
            begin
                changed_next = 1'b0;
            end
            default:
            begin
                held_next = held_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg     <= '0;
            deferred_reg <= '0;
            pedal_reg    <= 1'b0;
            changed_reg  <= 1'b0;
        end
        else if (step)
        begin
            held_reg     <= held_next;
            deferred_reg <= deferred_next;
            pedal_reg    <= pedal_next;
            changed_reg  <= changed_next;
        end
    end

    assign status.emit = emit;
    assign status.held = mhnt_pkg::SET_W'(held_reg);

    // pedal release empties the deferred set
    a_release_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && req.kind == mhnt_pkg::REQ_PEDAL && pedal_reg && !now_down
        |=> deferred_reg == '0)
        else $error("deferred set not cleared on pedal release");

    // an emitting end of block clears the change flag
    a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        step && emit |=> !changed_reg)
        else $error("change flag kept after snapshot");

endmodule

// File: rtl/midi_held_note_tracker_with_sustain.sv
// top level: input register, note state core and snapshot output register
// a transaction is captured in the input register and processed by the core when it proceeds;
//   its snapshot, if any, is then loaded into the output register
// throughput: one transaction per cycle while the input stage is not stalled
// reset: held and deferred sets, pedal and change flags cleared; sustain_enable set
// the input stage stalls only when a snapshot is due and the output register is full
module midi_held_note_tracker_with_sustain #(
    parameter int NOTE_COUNT = mhnt_pkg::NOTE_COUNT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [2:0]                    req_type,
    input  logic [mhnt_pkg::NOTE_W-1:0]   note_number,
    input  logic [mhnt_pkg::PEDAL_W-1:0]  pedal_value,
    input  logic [mhnt_pkg::TIME_W-1:0]   block_time,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [mhnt_pkg::HALF_W-1:0]   held_low,
    output logic [mhnt_pkg::HALF_W-1:0]   held_high,
    output logic [mhnt_pkg::TIME_W-1:0]   snapshot_time
);

    logic                         sustain_reg;
    logic                         in_vld_reg;
    logic                         in_vld_next;
    mhnt_pkg::req_t               req_reg;
    logic [mhnt_pkg::TIME_W-1:0]  time_reg;
    logic                         out_vld_reg;
    logic                         out_vld_next;
    logic [mhnt_pkg::SET_W-1:0]   held_out_reg;
    logic [mhnt_pkg::TIME_W-1:0]  time_out_reg;
    mhnt_pkg::core_status_t       status;
    logic                         produces;
    logic                         proceed;
    logic                         in_fire;

    assign produces    = in_vld_reg && status.emit;
    assign proceed     = in_vld_reg && (!produces || !out_vld_reg || out_ready);
    assign in_ready    = !in_vld_reg || proceed;
    assign in_fire     = in_valid && in_ready;
    assign in_vld_next = in_fire || (in_vld_reg && !proceed);
    assign out_vld_next = (proceed && produces) || (out_vld_reg && !out_ready);

    mhnt_core #(
        .NOTE_COUNT (NOTE_COUNT)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .sustain_enable (sustain_reg),
        .step           (proceed),
        .req            (req_reg),
        .status         (status)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sustain_reg <= 1'b1;
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                sustain_reg <= cfg_wdata;
            end
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            req_reg.kind  <= mhnt_pkg::req_type_t'(req_type);
            req_reg.note  <= note_number;
            req_reg.pedal <= pedal_value;
            time_reg      <= block_time;
        end
        if (proceed && produces)
        begin
            held_out_reg <= status.held;
            time_out_reg <= time_reg;
        end
    end

    assign out_valid     = out_vld_reg;
    assign held_low      = held_out_reg[mhnt_pkg::HALF_W-1:0];
    assign held_high     = held_out_reg[mhnt_pkg::SET_W-1:mhnt_pkg::HALF_W];
    assign snapshot_time = time_out_reg;

    // stalled transaction in the input register is kept
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld_reg && !proceed |=> in_vld_reg && $stable(req_reg) && $stable(time_reg))
        else $error("input register lost a stalled transaction");

    // a due snapshot lands in the output register with its block time
    a_snap_load: assert property (@(posedge clk) disable iff (!rst_n)
        proceed && produces |=> out_vld_reg && time_out_reg == $past(time_reg))
        else $error("snapshot not captured");

    // a waiting snapshot is never overwritten
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_vld_reg && !out_ready |=> out_vld_reg && $stable(held_out_reg)
            && $stable(time_out_reg))
        else $error("pending snapshot overwritten");

endmodule

// File: sim/tb.sv
// self-checking testbench for the midi held-note tracker with sustain pedal
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          RESET_CYC      = 7;
    localparam int          SETTLE_CYC     = 6;
    localparam int          IDLE_PCT       = 30;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          DRAIN_LIMIT    = 1000;
    localparam int          TAIL_CYC       = 8;
    localparam int          REPORT_MAX     = 10;
    localparam int          STEADY_FIRST   = 900;
    localparam int          STEADY_LAST    = 1300;
    localparam logic [2:0]  REQ_SPARE_FIRST = 3'd5;
    localparam logic [2:0]  REQ_SPARE_MID   = 3'd6;
    localparam logic [2:0]  REQ_SPARE_LAST  = 3'd7;

    typedef enum logic [1:0] {
        ACT_REQ,
        ACT_CFG,
        ACT_DRAIN
    } act_t;

    typedef struct {
        act_t                          act;
        logic [2:0]                    kind;
        logic [mhnt_pkg::NOTE_W-1:0]   note;
        logic [mhnt_pkg::PEDAL_W-1:0]  pedal;
        logic [mhnt_pkg::TIME_W-1:0]   stamp;
        logic                          cfg;
    } stim_t;

    typedef struct packed {
        logic [mhnt_pkg::HALF_W-1:0] lo;
        logic [mhnt_pkg::HALF_W-1:0] hi;
        logic [mhnt_pkg::TIME_W-1:0] stamp;
    } snap_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          cfg_we = 1'b0;
    logic                          cfg_wdata = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic [2:0]                    req_type = '0;
    logic [mhnt_pkg::NOTE_W-1:0]   note_number = '0;
    logic [mhnt_pkg::PEDAL_W-1:0]  pedal_value = '0;
    logic [mhnt_pkg::TIME_W-1:0]   block_time = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic [mhnt_pkg::HALF_W-1:0]   held_low;
    logic [mhnt_pkg::HALF_W-1:0]   held_high;
    logic [mhnt_pkg::TIME_W-1:0]   snapshot_time;

    stim_t pending_q[$];
    snap_t snapshot_q[$];

    // tracker state as predicted
    logic [mhnt_pkg::SET_W-1:0] held_set = '0;
    logic [mhnt_pkg::SET_W-1:0] release_set = '0;
    logic                       pedal_held = 1'b0;
    logic                       set_dirty = 1'b0;
    logic                       sustain_on = 1'b1;

    logic in_fire = 1'b0;
    int   n_in = 0;
    int   errors = 0;
    int   quiet_cyc = 0;
    int   settle = 0;
    logic steady;

    assign steady = (n_in >= STEADY_FIRST) && (n_in < STEADY_LAST);

    midi_held_note_tracker_with_sustain u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .note_number   (note_number),
        .pedal_value   (pedal_value),
        .block_time    (block_time),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .held_low      (held_low),
        .held_high     (held_high),
        .snapshot_time (snapshot_time)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= REPORT_MAX)
        begin
            $display("%s", msg);
        end
    endtask

    task automatic push_req(input logic [2:0] kind,
                            input logic [mhnt_pkg::NOTE_W-1:0] note,
                            input logic [mhnt_pkg::PEDAL_W-1:0] pedal,
                            input logic [mhnt_pkg::TIME_W-1:0] stamp);
        stim_t s;
        s.act   = ACT_REQ;
        s.kind  = kind;
        s.note  = note;
        s.pedal = pedal;
        s.stamp = stamp;
        s.cfg   = 1'b0;
        pending_q = {pending_q, s};
    endtask

    task automatic push_ctl(input act_t act, input logic val);
        stim_t s;
        s.act   = act;
        s.kind  = '0;
        s.note  = '0;
        s.pedal = '0;
        s.stamp = '0;
        s.cfg   = val;
        pending_q = {pending_q, s};
    endtask

    function automatic logic [mhnt_pkg::PEDAL_W-1:0] rnd7();
        return mhnt_pkg::PEDAL_W'($urandom_range(127));
    endfunction

    function automatic logic [mhnt_pkg::PEDAL_W-1:0] pick_pedal();
        case ($urandom_range(5))
            0: return mhnt_pkg::PEDAL_W'(mhnt_pkg::PEDAL_DOWN_MIN);
            1: return mhnt_pkg::PEDAL_W'(mhnt_pkg::PEDAL_DOWN_MIN - 1);
            2: return '0;
            3: return '1;
            default: return rnd7();
        endcase
    endfunction

    // short phrases around a root note so on/off/pedal events hit the same keys
    task automatic add_phrase(input int len);
        logic [mhnt_pkg::NOTE_W-1:0] root;
        logic [mhnt_pkg::NOTE_W-1:0] nt;
        int                          k;
        int                          pick;
        root = mhnt_pkg::NOTE_W'($urandom_range(127));
        for (k = 0; k < len; k++)
        begin
            pick = $urandom_range(99);
            if ($urandom_range(4) == 0)
                nt = mhnt_pkg::NOTE_W'($urandom_range(127));
            else
                nt = root + mhnt_pkg::NOTE_W'($urandom_range(11));
            if (pick < 36)
                push_req(mhnt_pkg::REQ_NOTE_ON, nt, rnd7(), $urandom);
            else if (pick < 66)
                push_req(mhnt_pkg::REQ_NOTE_OFF, nt, rnd7(), $urandom);
            else if (pick < 76)
                push_req(mhnt_pkg::REQ_PEDAL, nt, pick_pedal(), $urandom);
            else if (pick < 94)
                push_req(mhnt_pkg::REQ_END_BLOCK, nt, rnd7(), $urandom);
            else if (pick < 97)
                push_req(mhnt_pkg::REQ_ALL_OFF, nt, rnd7(), $urandom);
            else
                push_req(3'($urandom_range(REQ_SPARE_LAST, REQ_SPARE_FIRST)), nt, rnd7(),
                         $urandom);
        end
    endtask

    task automatic add_phrases(input int total);
        int len;
        while (total > 0)
        begin
            len = $urandom_range(40, 8);
            add_phrase(len);
            total -= len;
        end
    endtask

    task automatic track_event(input logic [2:0] kind,
                               input logic [mhnt_pkg::NOTE_W-1:0] note,
                               input logic [mhnt_pkg::PEDAL_W-1:0] pedal,
                               input logic [mhnt_pkg::TIME_W-1:0] stamp);
        logic  now_down;
        snap_t snap;
        if (kind == mhnt_pkg::REQ_NOTE_ON && int'(note) < mhnt_pkg::NOTE_COUNT_DEF)
        begin
            release_set[note] = 1'b0;
            if (!held_set[note])
                set_dirty = 1'b1;
            held_set[note] = 1'b1;
        end
        else if (kind == mhnt_pkg::REQ_NOTE_OFF && int'(note) < mhnt_pkg::NOTE_COUNT_DEF)
        begin
            if (sustain_on && pedal_held)
                release_set[note] = 1'b1;
            else
            begin
                if (held_set[note])
                    set_dirty = 1'b1;
                held_set[note] = 1'b0;
            end
        end
        else if (kind == mhnt_pkg::REQ_PEDAL)
        begin
            now_down = (int'(pedal) >= mhnt_pkg::PEDAL_DOWN_MIN);
            if (pedal_held && !now_down)
            begin
                if ((held_set & release_set) != '0)
                    set_dirty = 1'b1;
                held_set    = held_set & ~release_set;
                release_set = '0;
            end
            pedal_held = now_down;
        end
        else if (kind == mhnt_pkg::REQ_ALL_OFF)
        begin
            if (held_set != '0)
                set_dirty = 1'b1;
            held_set    = '0;
            release_set = '0;
        end
        else if (kind == mhnt_pkg::REQ_END_BLOCK && set_dirty)
        begin
            set_dirty  = 1'b0;
            snap.lo    = held_set[mhnt_pkg::HALF_W-1:0];
            snap.hi    = held_set[mhnt_pkg::SET_W-1:mhnt_pkg::HALF_W];
            snap.stamp = stamp;
            snapshot_q = {snapshot_q, snap};
        end
    endtask

    // driver
    always @(negedge clk)
    begin : drive_blk
        stim_t head;
        logic  we_n;
        we_n = 1'b0;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (in_valid && !in_fire)
        begin
            in_valid <= 1'b1;
        end
        else if (pending_q.size() == 0)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            head = pending_q[0];
            if (head.act == ACT_REQ)
            begin
                if (!steady && $urandom_range(99) < IDLE_PCT)
                begin
                    in_valid <= 1'b0;
                end
                else
                begin
                    void'(pending_q.pop_front());
                    req_type    <= head.kind;
                    note_number <= head.note;
                    pedal_value <= head.pedal;
                    block_time  <= head.stamp;
                    in_valid    <= 1'b1;
                end
            end
            else
            begin
                in_valid <= 1'b0;
                if (snapshot_q.size() != 0)
                    settle <= 0;
                else if (settle < SETTLE_CYC)
                    settle <= settle + 1;
                else
                begin
                    void'(pending_q.pop_front());
                    settle <= 0;
                    if (head.act == ACT_CFG)
                    begin
                        we_n = 1'b1;
                        cfg_wdata <= head.cfg;
                    end
                end
            end
        end
        cfg_we <= we_n;
    end

    // receiver backpressure
    always @(negedge clk)
    begin
        out_ready <= rst_n && (steady || $urandom_range(99) >= IDLE_PCT);
    end

    // monitor, predictor and watchdog
    always @(posedge clk or negedge rst_n)
    begin : mon_blk
        snap_t want;
        logic  bad;
        if (!rst_n)
        begin
            in_fire   <= 1'b0;
            quiet_cyc <= 0;
        end
        else
        begin
            in_fire <= in_valid && in_ready;
            if (cfg_we)
                sustain_on = cfg_wdata;
            if (in_valid && in_ready)
            begin
                track_event(req_type, note_number, pedal_value, block_time);
                n_in++;
            end
            if (out_valid && out_ready)
            begin
                if (snapshot_q.size() == 0)
                begin
                    flag_error($sformatf("unexpected snapshot: low %h high %h time %h",
                                         held_low, held_high, snapshot_time));
                end
                else
                begin
                    want = snapshot_q.pop_front();
                    bad  = 1'b0;
                    if (held_low !== want.lo)
                    begin
                        bad = 1'b1;
                    end
                    if (held_high !== want.hi)
                    begin
                        bad = 1'b1;
                    end
                    if (snapshot_time !== want.stamp)
                    begin
                        bad = 1'b1;
                    end
                    if (bad)
                    begin
                        flag_error($sformatf({"snapshot mismatch: held_low exp %h got %h, ",
                                              "held_high exp %h got %h, time exp %h got %h"},
                                             want.lo, held_low, want.hi, held_high,
                                             want.stamp, snapshot_time));
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
                quiet_cyc <= 0;
            else if (quiet_cyc >= WATCHDOG_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
            else
                quiet_cyc <= quiet_cyc + 1;
        end
    end

    initial
    begin : stim_blk
        int guard;

        // empty block, then held-set changes and repeats
        push_req(mhnt_pkg::REQ_END_BLOCK, 7'd0, 7'd0, 32'h0000_0000);
        push_req(mhnt_pkg::REQ_NOTE_ON, 7'd0, 7'd127, 32'h1234_5678);
        push_req(mhnt_pkg::REQ_NOTE_ON, 7'd127, 7'd0, 32'h0);
        push_req(mhnt_pkg::REQ_NOTE_ON, 7'd0, 7'd64, 32'h0);
        push_req(mhnt_pkg::REQ_END_BLOCK, 7'd127, 7'd127, 32'hFFFF_FFFF);
        push_req(mhnt_pkg::REQ_END_BLOCK, 7'd0, 7'd0, 32'h0000_0001);
        // pedal down defers releases, including a note that is not held
        push_req(mhnt_pkg::REQ_PEDAL, 7'd0, 7'd64, 32'h0);
        push_req(mhnt_pkg::REQ_NOTE_OFF, 7'd0, 7'd0, 32'h0);
        push_req(mhnt_pkg::REQ_NOTE_OFF, 7'd5, 7'd0, 32'h0);
        push_req(mhnt_pkg::REQ_NOTE_OFF, 7'd127, 7'd0, 32'h0);
        push_req(mhnt_pkg::REQ_END_BLOCK, 7'd0, 7'd0, 32'h5555_AAAA);
        push_req(mhnt_pkg::REQ_NOTE_ON, 7'd0, 7'd0, 32'h0);
        push_req(mhnt_pkg::REQ_PEDAL, 7'd0, 7'd63, 32'h0);
        push_req(mhnt_pkg::REQ_END_BLOCK, 7'd0, 7'd0, 32'h8000_0000);
        // all-notes-off keeps the pedal down
        push_req(mhnt_pkg::REQ_PEDAL, 7'd0, 7'd127, 32'h0);
        push_req(mhnt_pkg::REQ_NOTE_OFF, 7'd0, 7'd0, 32'h0);
        push_req(mhnt_pkg::REQ_ALL_OFF, 7'd127, 7'd127, 32'h0);
        push_req(mhnt_pkg::REQ_NOTE_ON, 7'd64, 7'd0, 32'h0);
        push_req(mhnt_pkg::REQ_NOTE_OFF, 7'd64, 7'd0, 32'h0);
        push_req(mhnt_pkg::REQ_END_BLOCK, 7'd0, 7'd0, 32'h0000_FFFF);
        // spare request codes do nothing
        push_req(REQ_SPARE_FIRST, 7'd64, 7'd127, 32'hFFFF_FFFF);
        push_req(REQ_SPARE_MID, 7'd127, 7'd0, 32'h0);
        push_req(REQ_SPARE_LAST, 7'd1, 7'd64, 32'hDEAD_BEEF);
        push_req(mhnt_pkg::REQ_PEDAL, 7'd0, 7'd0, 32'h0);
        push_req(mhnt_pkg::REQ_END_BLOCK, 7'd0, 7'd0, 32'hAAAA_5555);
        // deferred note released on pedal up after sustain is switched off
        push_req(mhnt_pkg::REQ_PEDAL, 7'd0, 7'd100, 32'h0);
        push_req(mhnt_pkg::REQ_NOTE_ON, 7'd10, 7'd0, 32'h0);
        push_req(mhnt_pkg::REQ_NOTE_OFF, 7'd10, 7'd0, 32'h0);
        push_req(mhnt_pkg::REQ_END_BLOCK, 7'd0, 7'd0, 32'h0000_0010);
        push_ctl(ACT_CFG, 1'b0);
        push_req(mhnt_pkg::REQ_NOTE_OFF, 7'd20, 7'd0, 32'h0);
        push_req(mhnt_pkg::REQ_PEDAL, 7'd0, 7'd0, 32'h0);
        push_req(mhnt_pkg::REQ_END_BLOCK, 7'd0, 7'd0, 32'h0000_0020);

        // random phrases across sustain settings
        push_ctl(ACT_CFG, 1'b1);
        add_phrases(700);
        push_ctl(ACT_DRAIN, 1'b0);
        add_phrases(300);
        push_ctl(ACT_CFG, 1'b0);
        add_phrases(500);
        push_ctl(ACT_CFG, 1'b1);
        add_phrases(500);

        repeat (RESET_CYC) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        wait (pending_q.size() == 0 && !in_valid);
        guard = 0;
        while (snapshot_q.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (TAIL_CYC) @(posedge clk);
        if (snapshot_q.size() != 0)
            flag_error($sformatf("%0d snapshots never arrived", snapshot_q.size()));

        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
rtl/mhnt_pkg.sv
rtl/mhnt_core.sv
rtl/midi_held_note_tracker_with_sustain.sv
sim/tb.sv
